### hdl/cda_pkg.sv
// Shared types, command codes and calendar helpers for the date adder.
`timescale 1ns / 1ps

package cda_pkg;

  localparam int YEAR_BITS_DEF = 16;

  localparam logic [1:0] OP_DAYS   = 2'd0;
  localparam logic [1:0] OP_MONTHS = 2'd1;
  localparam logic [1:0] OP_YEARS  = 2'd2;
  localparam logic [1:0] OP_LOAD   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] amount;
    logic [15:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
  } cda_in_t;

  typedef struct packed {
    logic [15:0] date_year;
    logic [3:0]  date_month;
    logic [4:0]  date_day;
    logic        year_overflow;
  } cda_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic day_step;
    logic div_go;
    logic div_year;
    logic apply_q;
    logic take_rem;
    logic fix_spill;
    logic fix_load;
    logic emit;
  } cda_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic day_fits;
    logic div_busy;
  } cda_sts_t;

  // Leap year from the year modulo 400: divisible by 4 and not a century,
  // unless it is a multiple of 400.
  function automatic logic is_leap(input logic [8:0] r400);
    return (r400[1:0] == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200) &&
           (r400 != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    begin
      case (m)
        4'd2:    len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
        default: len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

### hdl/cda_sdiv.sv
// Constant divider: a month count by 12 or a year modulo 400, in three steps after go.
`timescale 1ns / 1ps

module cda_sdiv #(
  parameter int W = 17
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic         by_year,
  input  logic [W-1:0] dividend,
  output logic         busy,
  output logic [12:0]  quot,
  output logic [8:0]   rem
);

  // 2^21 / 12 and 2^17 / 25, rounded up; both are exact over the operand ranges used here.
  localparam logic [17:0] RECIP_12  = 18'd174763;
  localparam logic [12:0] RECIP_25  = 13'd5243;
  // A multiple of 25 that keeps the second fold from going negative.
  localparam logic [11:0] FOLD_BIAS = 12'd2050;

  logic        busy_r, busy_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic        mode_r, mode_nxt;
  logic [3:0]  lo4_r, lo4_nxt;
  logic [20:0] f_r, f_nxt;
  logic [11:0] a_r, a_nxt;
  logic [12:0] q_r, q_nxt;
  logic [8:0]  r_r, r_nxt;

  logic [27:0] y16;
  logic [20:0] fold;
  logic [34:0] prod12;
  logic [24:0] prod25;
  logic [16:0] back12;
  logic [11:0] back25;
  logic [16:0] rem12;
  logic [11:0] rem25;

  // The year modulo 400 is sixteen times (year / 16 mod 25) plus the low four bits.
  // Modulo 25, 2^20 is 1 and 2^10 is -1, so the chunks fold by add and subtract.
  assign y16    = 28'(dividend >> 4);
  assign fold   = 21'(y16[19:0]) + 21'(y16[27:20]);
  assign prod12 = 35'(f_r[16:0]) * 35'(RECIP_12);
  assign prod25 = 25'(a_r) * 25'(RECIP_25);
  assign back12 = 17'(q_r) * 17'd12;
  assign back25 = 12'(q_r) * 12'd25;
  assign rem12  = f_r[16:0] - back12;
  assign rem25  = a_r - back25;

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    mode_nxt = mode_r;
    lo4_nxt  = lo4_r;
    f_nxt    = f_r;
    a_nxt    = a_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    if (go) begin
      busy_nxt = 1'b1;
      ph_nxt   = 2'd0;
      mode_nxt = by_year;
      lo4_nxt  = dividend[3:0];
      f_nxt    = by_year ? fold : 21'(dividend[16:0]);
    end else if (busy_r) begin
      ph_nxt = ph_r + 2'd1;
      case (ph_r)
        2'd0: begin
          if (mode_r) begin
            a_nxt = 12'(f_r[9:0]) + FOLD_BIAS - 12'(f_r[20:10]);
          end else begin
            q_nxt = prod12[33:21];
          end
        end
        2'd1: begin
          if (mode_r) begin
            q_nxt = 13'(prod25[24:17]);
          end else begin
            r_nxt = 9'(rem12);
          end
        end
        default: begin
          if (mode_r) begin
            r_nxt = {rem25[4:0], lo4_r};
          end
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    lo4_r  <= lo4_nxt;
    f_r    <= f_nxt;
    a_r    <= a_nxt;
    q_r    <= q_nxt;
    r_r    <= r_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

### hdl/cda_dp.sv
// Datapath: date registers, year-mod-400 tracking, month walk and result register.
`timescale 1ns / 1ps

module cda_dp #(
  parameter int YEAR_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cda_pkg::cda_in_t  in_item,
  input  cda_pkg::cda_ctl_t ctl,
  output cda_pkg::cda_sts_t sts,
  output logic              out_valid,
  output cda_pkg::cda_out_t out_item
);

  import cda_pkg::*;

  localparam int DIV_W = (YEAR_BITS > 17) ? YEAR_BITS : 17;

  logic [YEAR_BITS-1:0] year_r, year_nxt;
  logic [8:0]           rem400_r, rem400_nxt;
  logic [3:0]           month_r, month_nxt;
  logic [4:0]           day_r, day_nxt;
  logic [15:0]          left_r, left_nxt;
  logic [15:0]          amt_r, amt_nxt;
  logic                 wrap_r, wrap_nxt;
  logic                 out_valid_r;
  cda_out_t             out_item_r;

  logic                 leap;
  logic [4:0]           last;
  logic [16:0]          day_sum;
  logic [5:0]           step;
  logic [3:0]           month_inc;
  logic [YEAR_BITS-1:0] year_inc;
  logic                 inc_wrap;
  logic [8:0]           rem_inc;
  logic [DIV_W-1:0]     addend;
  logic [DIV_W:0]       sum;
  logic                 sum_wrap;
  logic [YEAR_BITS-1:0] sum_year;
  logic [DIV_W-1:0]     div_dividend;
  logic                 div_busy;
  logic [12:0]          div_quot;
  logic [8:0]           div_rem;
  logic [3:0]           load_m;
  logic [4:0]           load_d;

  assign leap    = is_leap(rem400_r);
  assign last    = month_len(month_r, leap);
  assign day_sum = 17'(day_r) + 17'(left_r);
  // Zero when a day sits one past the month end (Feb 29 after a year add).
  assign step    = 6'(last) - 6'(day_r) + 6'd1;

  assign month_inc = (month_r == 4'd12) ? 4'd1 : month_r + 4'd1;
  assign year_inc  = year_r + YEAR_BITS'(1);
  assign inc_wrap  = &year_r;
  assign rem_inc   = inc_wrap ? 9'd0 : ((rem400_r == 9'd399) ? 9'd0 : rem400_r + 9'd1);

  assign addend   = ctl.apply_q ? DIV_W'(div_quot) : DIV_W'(in_item.amount);
  assign sum      = (DIV_W+1)'(year_r) + (DIV_W+1)'(addend);
  assign sum_wrap = (sum >> YEAR_BITS) != '0;
  assign sum_year = sum[YEAR_BITS-1:0];

  assign div_dividend = ctl.div_year ? DIV_W'(year_r)
                                     : DIV_W'(month_r) - DIV_W'(1) + DIV_W'(amt_r);

  assign load_m = (in_item.load_month == 4'd0) ? 4'd1 :
                  (in_item.load_month > 4'd12) ? 4'd12 : in_item.load_month;
  assign load_d = (day_r == 5'd0) ? 5'd1 : day_r;

  cda_sdiv #(
    .W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (ctl.div_go),
    .by_year  (ctl.div_year),
    .dividend (div_dividend),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    year_nxt   = year_r;
    rem400_nxt = rem400_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    left_nxt   = left_r;
    amt_nxt    = amt_r;
    wrap_nxt   = wrap_r;

    if (ctl.capture) begin
      wrap_nxt = 1'b0;
      amt_nxt  = in_item.amount;
      case (in_item.cmd)
        OP_DAYS: begin
          left_nxt = in_item.amount;
        end
        OP_YEARS: begin
          year_nxt = sum_year;
          wrap_nxt = sum_wrap;
        end
        OP_LOAD: begin
          year_nxt  = YEAR_BITS'(in_item.load_year);
          month_nxt = load_m;
          day_nxt   = in_item.load_day;
        end
        default: begin
        end
      endcase
    end

    if (ctl.day_step) begin
      if (day_sum <= 17'(last)) begin
        day_nxt = day_sum[4:0];
      end else begin
        left_nxt  = left_r - 16'(step);
        day_nxt   = 5'd1;
        month_nxt = month_inc;
        if (month_r == 4'd12) begin
          year_nxt   = year_inc;
          rem400_nxt = rem_inc;
          wrap_nxt   = wrap_r | inc_wrap;
        end
      end
    end

    if (ctl.apply_q) begin
      year_nxt  = sum_year;
      wrap_nxt  = wrap_r | sum_wrap;
      month_nxt = div_rem[3:0] + 4'd1;
    end

    if (ctl.take_rem) begin
      rem400_nxt = div_rem;
    end

    if (ctl.fix_spill && (day_r > last)) begin
      day_nxt   = day_r - last;
      month_nxt = month_inc;
      if (month_r == 4'd12) begin
        year_nxt   = year_inc;
        rem400_nxt = rem_inc;
        wrap_nxt   = wrap_r | inc_wrap;
      end
    end

    if (ctl.fix_load) begin
      day_nxt = (load_d > last) ? last : load_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r      <= YEAR_BITS'(1);
      rem400_r    <= 9'd1;
      month_r     <= 4'd1;
      day_r       <= 5'd1;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      year_r      <= year_nxt;
      rem400_r    <= rem400_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      wrap_r      <= wrap_nxt;
      out_valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    amt_r  <= amt_nxt;
    if (ctl.emit) begin
      out_item_r.date_year     <= 16'(year_r);
      out_item_r.date_month    <= month_r;
      out_item_r.date_day      <= day_r;
      out_item_r.year_overflow <= wrap_r;
    end
  end

  assign sts.day_fits = day_sum <= 17'(last);
  assign sts.div_busy = div_busy;
  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;

endmodule

### hdl/cda_ctrl.sv
// Controller state machine that sequences each command through the datapath.
`timescale 1ns / 1ps

module cda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_cmd,
  input  cda_pkg::cda_sts_t sts,
  output cda_pkg::cda_ctl_t ctl,
  output logic              busy
);

  import cda_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DAYS   = 4'd1;
  localparam logic [3:0] S_MGO    = 4'd2;
  localparam logic [3:0] S_MWAIT  = 4'd3;
  localparam logic [3:0] S_MAPPLY = 4'd4;
  localparam logic [3:0] S_YGO    = 4'd5;
  localparam logic [3:0] S_YWAIT  = 4'd6;
  localparam logic [3:0] S_FIX    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          op_nxt      = in_cmd;
          case (in_cmd)
            OP_DAYS:   state_nxt = S_DAYS;
            OP_MONTHS: state_nxt = S_MGO;
            default:   state_nxt = S_YGO;
          endcase
        end
      end
      S_DAYS: begin
        ctl.day_step = 1'b1;
        if (sts.day_fits) begin
          state_nxt = S_EMIT;
        end
      end
      S_MGO: begin
        ctl.div_go = 1'b1;
        state_nxt  = S_MWAIT;
      end
      S_MWAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_MAPPLY;
        end
      end
      S_MAPPLY: begin
        ctl.apply_q = 1'b1;
        state_nxt   = S_YGO;
      end
      S_YGO: begin
        ctl.div_go   = 1'b1;
        ctl.div_year = 1'b1;
        state_nxt    = S_YWAIT;
      end
      S_YWAIT: begin
        ctl.div_year = 1'b1;
        if (!sts.div_busy) begin
          ctl.take_rem = 1'b1;
          state_nxt    = S_FIX;
        end
      end
      S_FIX: begin
        ctl.fix_spill = (op_r == OP_MONTHS);
        ctl.fix_load  = (op_r == OP_LOAD);
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        ctl.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_DAYS;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

### hdl/calendar_date_adder.sv
// Top level of the Gregorian date adder: controller plus datapath.
`timescale 1ns / 1ps

// A command item is taken when start is high and busy is low; busy stays high
// until the item is finished, and the result then appears on out_item for one
// cycle with out_valid high, with no way for the receiver to hold it off.
// A new item may be started in the cycle the result is shown. A day add keeps
// busy high while the month-walk loop steps across each month boundary. A year
// add or a load passes once through the three-step constant divider, which
// finds the year modulo 400 for the leap rule; a month add passes through it
// twice, first to reduce the month count by 12.

module calendar_date_adder #(
  parameter int YEAR_BITS = cda_pkg::YEAR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cda_pkg::cda_in_t  in_item,
  output logic              out_valid,
  output cda_pkg::cda_out_t out_item
);

  import cda_pkg::*;

  cda_ctl_t ctl;
  cda_sts_t sts;

  cda_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_item.cmd),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  cda_dp #(
    .YEAR_BITS (YEAR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
